### sv/dttfp_pkg.sv
// Shared constants and control/status types for the decimal text to fixed point block.
// No dependencies.
`default_nettype none

package dttfp_pkg;

  localparam int unsigned FRACTION_DIGITS_DEF = 8;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned FBITS_W = 6;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2e;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] DIGIT_MAX  = 8'd9;

  localparam logic [FBITS_W-1:0] FBITS_RESET = 6'd16;
  localparam logic [FBITS_W-1:0] FBITS_MAX   = 6'd32;

  typedef struct packed {
    logic accept;    // parse one accepted character
    logic start;     // terminator accepted: seed value from integer part
    logic shift;     // one BCD doubling step
    logic load_out;  // write result register and clear parse state
  } dttfp_cmd_t;

  typedef struct packed {
    logic               term;   // current input character is the terminator
    logic [FBITS_W-1:0] steps;  // doubling steps, fraction bits clamped to 32
  } dttfp_stat_t;

endpackage

`default_nettype wire

### sv/decimal_text_to_fixed_point.sv
// Top level: decimal ASCII text to signed 32-bit fixed point.
// Depends on dttfp_pkg, dttfp_ctrl, dttfp_dp.
//
//   channel | signals                            | direction
//   in      | in_valid_i, in_stall_o, character_i | request in
//   out     | out_valid_o, out_stall_i, fixed_value_o | request out
//   cfg     | cfg_we_i, cfg_wdata_i               | register write
//
// Any character other than the terminator is taken without stalling the input.
// After the terminator's accept, the block runs min(fraction_bits, 32) BCD doubling steps,
// one bit each, then loads the result register; input is stalled after the accept
// until the load.
// The result register holds while out_stall_i is high; the load waits for it to drain.
// Reset sets fraction_bits to 16 and clears all parse state.
`default_nettype none

module decimal_text_to_fixed_point import dttfp_pkg::*; #(
  parameter int unsigned FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [CHAR_W-1:0]     character_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic signed [VALUE_W-1:0]  fixed_value_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [FBITS_W-1:0]    cfg_wdata_i
);

  dttfp_cmd_t  cmd;
  dttfp_stat_t stat;

  dttfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dttfp_dp #(
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .character_i   (character_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .fixed_value_o (fixed_value_o)
  );

endmodule

`default_nettype wire

### sv/dttfp_dp.sv
// Datapath: character parser, integer accumulator, BCD fraction store, shift value, result.
// Depends on dttfp_pkg.
`default_nettype none

module dttfp_dp import dttfp_pkg::*; #(
  parameter int unsigned FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [CHAR_W-1:0]         character_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [FBITS_W-1:0]        cfg_wdata_i,
  input  wire dttfp_cmd_t                cmd_i,
  output dttfp_stat_t                    stat_o,
  output logic signed [VALUE_W-1:0]      fixed_value_o
);

  localparam int unsigned CNT_W = $clog2(FRACTION_DIGITS + 1);

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_INT   = 2'd1,
    PH_WAIT  = 2'd2,
    PH_FRAC  = 2'd3
  } phase_e;

  logic [FBITS_W-1:0] fbits_q;
  phase_e             phase_q, phase_d;
  logic               neg_q, neg_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [3:0]         digits_q [FRACTION_DIGITS];
  logic [3:0]         digits_d [FRACTION_DIGITS];
  logic [VALUE_W-1:0] val_q, val_d;
  logic [VALUE_W-1:0] out_q, out_d;

  logic               is_digit;
  logic [3:0]         digit_val;
  logic [CHAR_W-1:0]  char_off;
  logic [FRACTION_DIGITS:0] carry;

  assign char_off  = character_i - CHAR_ZERO;
  assign is_digit  = (character_i >= CHAR_ZERO) && (char_off <= DIGIT_MAX);
  assign digit_val = is_digit ? char_off[3:0] : 4'd0;

  assign stat_o.term  = (character_i == CHAR_NUL);
  assign stat_o.steps = (fbits_q > FBITS_MAX) ? FBITS_MAX : fbits_q;

  // carry out of a doubled digit depends only on that digit
  always_comb begin
    carry[0] = 1'b0;
    for (int i = 0; i < FRACTION_DIGITS; i++) begin
      carry[i+1] = (digits_q[i] >= 4'd5);
    end
  end

  always_comb begin
    logic [4:0] dbl;
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    val_d   = val_q;
    out_d   = out_q;
    for (int i = 0; i < FRACTION_DIGITS; i++) begin
      digits_d[i] = digits_q[i];
    end
    dbl = '0;

    if (cmd_i.accept && !stat_o.term) begin
      unique case (phase_q)
        PH_START, PH_INT: begin
          if (phase_q == PH_START && character_i == CHAR_MINUS) begin
            neg_d   = 1'b1;
            phase_d = PH_INT;
          end else if (is_digit) begin
            acc_d   = (acc_q << 3) + (acc_q << 1) + VALUE_W'(digit_val);
            phase_d = PH_INT;
          end else if (character_i == CHAR_POINT) begin
            phase_d = PH_FRAC;
          end else begin
            phase_d = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (character_i == CHAR_POINT) begin
            phase_d = PH_FRAC;
          end
        end
        default: begin
          if (cnt_q < CNT_W'(FRACTION_DIGITS)) begin
            for (int i = 0; i < FRACTION_DIGITS; i++) begin
              if (CNT_W'(FRACTION_DIGITS - 1 - i) == cnt_q) begin
                digits_d[i] = digit_val;
              end
            end
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      endcase
    end

    if (cmd_i.start) begin
      val_d = acc_q;
    end

    if (cmd_i.shift) begin
      for (int i = 0; i < FRACTION_DIGITS; i++) begin
        dbl = {digits_q[i], carry[i]};
        digits_d[i] = carry[i+1] ? 4'(dbl - 5'd10) : dbl[3:0];
      end
      val_d = {val_q[VALUE_W-2:0], carry[FRACTION_DIGITS]};
    end

    if (cmd_i.load_out) begin
      out_d   = neg_q ? (~val_q + VALUE_W'(1)) : val_q;
      phase_d = PH_START;
      neg_d   = 1'b0;
      acc_d   = '0;
      cnt_d   = '0;
      for (int i = 0; i < FRACTION_DIGITS; i++) begin
        digits_d[i] = 4'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fbits_q <= FBITS_RESET;
      phase_q <= PH_START;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      cnt_q   <= '0;
      for (int i = 0; i < FRACTION_DIGITS; i++) begin
        digits_q[i] <= 4'd0;
      end
    end else begin
      if (cfg_we_i) begin
        fbits_q <= cfg_wdata_i;
      end
      phase_q <= phase_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      for (int i = 0; i < FRACTION_DIGITS; i++) begin
        digits_q[i] <= digits_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    out_q <= out_d;
  end

  assign fixed_value_o = signed'(out_q);

endmodule

`default_nettype wire

### sv/dttfp_ctrl.sv
// Controller: request handshakes, doubling step counter and result valid.
// Depends on dttfp_pkg.
`default_nettype none

module dttfp_ctrl import dttfp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  input  wire dttfp_stat_t stat_i,
  output dttfp_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    S_PARSE  = 2'd0,
    S_DOUBLE = 2'd1,
    S_EMIT   = 2'd2
  } state_e;

  state_e             state_q;
  logic [FBITS_W-1:0] steps_q;
  logic               out_valid_q;

  assign in_stall_o  = (state_q != S_PARSE);
  assign out_valid_o = out_valid_q;

  assign cmd_o.accept   = (state_q == S_PARSE) && in_valid_i;
  assign cmd_o.start    = cmd_o.accept && stat_i.term;
  assign cmd_o.shift    = (state_q == S_DOUBLE);
  assign cmd_o.load_out = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_PARSE;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_PARSE: begin
          if (cmd_o.start) begin
            steps_q <= stat_i.steps;
            state_q <= (stat_i.steps == '0) ? S_EMIT : S_DOUBLE;
          end
        end
        S_DOUBLE: begin
          steps_q <= steps_q - FBITS_W'(1);
          if (steps_q == FBITS_W'(1)) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (cmd_o.load_out) begin
            state_q <= S_PARSE;
          end
        end
        default: begin
          state_q <= S_PARSE;
        end
      endcase
    end
  end

  a_double_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DOUBLE) |-> (steps_q != '0))
    else $error("doubling with zero steps left");

  a_last_step_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DOUBLE && steps_q == FBITS_W'(1)) |=> (state_q == S_EMIT))
    else $error("last doubling step did not reach emit");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

  a_start_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.start && stat_i.steps == '0) |=> (state_q == S_EMIT))
    else $error("zero fraction bits did not go straight to emit");

endmodule

`default_nettype wire
